// ----- hw/rtl/rts_pkg.sv -----
// Shared types and constants for the rational timebase scaler.
package rts_pkg;

	localparam int unsigned TIME_W  = 64;
	localparam int unsigned SCALE_W = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DENOMINATOR = 1'b1;

	// Divider request: start pulse with operands
	typedef struct packed {
		logic               start;
		logic [TIME_W-1:0]  dividend;
		logic [SCALE_W-1:0] divisor;
	} rts_div_req_t;

	// Divider status and results
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [TIME_W-1:0]  quotient;
		logic [SCALE_W-1:0] remainder;
	} rts_div_rsp_t;

endpackage

// ----- hw/rtl/rts_if.sv -----
// Valid/ready stream interfaces for raw samples and scaled results.
interface rts_raw_if
	import rts_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] raw_time;

	modport source (output valid, output raw_time, input ready);
	modport sink   (input valid, input raw_time, output ready);
endinterface

interface rts_scaled_if
	import rts_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] scaled_time;

	modport source (output valid, output scaled_time, input ready);
	modport sink   (input valid, input scaled_time, output ready);
endinterface

// ----- hw/rtl/rts_div.sv -----
// Restoring bit-serial divider: 64-bit dividend by 32-bit divisor, one bit per cycle.
module rts_div
	import rts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  rts_div_req_t req,
	output rts_div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(TIME_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TIME_W-1:0]   quo_q;
	logic [SCALE_W-1:0]  rem_q;
	logic [SCALE_W-1:0]  dvs_q;
	logic [SCALE_W:0]    trial;
	logic [SCALE_W:0]    diff;
	logic                fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[TIME_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	// Control: count quotient bits, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then advance one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TIME_W-2:0], fits};
			rem_q <= fits ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- hw/rtl/rational_timebase_scaler.sv -----
// Top level of the rational timebase scaler: raw counter samples in, scaled count out.
//
// Channels: raw carries one 64-bit raw counter sample per request; scaled
// returns exactly one 64-bit result per request. Both use valid/ready and a
// request moves when valid and ready are high at a rising edge of clk.
// Configuration: cfg_we writes cfg_data into the numerator (index 0) or the
// denominator (index 1); write only while no request is in flight.
// Operation: when numerator equals denominator the sample is loaded
// unchanged into the output register as it is accepted.
// Otherwise a request runs a shift-and-add multiply (one numerator bit a
// cycle), then a restoring division (one quotient bit a cycle), then the
// count update and the output load. One request is worked at a time; the
// next one is accepted once the block is idle.
// Reset (arst_n low): numerator and denominator return to 1, stored sample
// and remainder to 0, scaled count to 1, output register empty.
// Stall: a result waits in the output register while scaled.ready is low;
// raw.ready stays low until the output register can take the next result.
module rational_timebase_scaler
	import rts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	rts_raw_if.sink              raw,
	rts_scaled_if.source         scaled,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data
);

	localparam int unsigned MUL_CNT_W = $clog2(SCALE_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]            state_q;
	logic [SCALE_W-1:0]    num_q;
	logic [SCALE_W-1:0]    den_q;
	logic [TIME_W-1:0]     prev_q;
	logic [SCALE_W-1:0]    rem_q;
	logic [TIME_W-1:0]     count_q;
	logic [TIME_W-1:0]     mcand_q;
	logic [SCALE_W-1:0]    mplier_q;
	logic [TIME_W-1:0]     acc_q;
	logic [TIME_W-1:0]     acc_d;
	logic [MUL_CNT_W-1:0]  mcnt_q;
	logic                  out_valid_q;
	logic [TIME_W-1:0]     out_data_q;
	logic                  in_take;
	logic                  out_free;
	logic                  passthru;
	logic [SCALE_W-1:0]    divisor;
	rts_div_req_t          div_req;
	rts_div_rsp_t          div_rsp;

	// Handshake
	assign out_free  = !out_valid_q || scaled.ready;
	assign raw.ready = (state_q == ST_IDLE) && out_free;
	assign in_take   = raw.valid && raw.ready;
	assign passthru  = (num_q == den_q);

	// A zero denominator divides by one
	assign divisor = (den_q == '0) ? SCALE_W'(1) : den_q;

	// Multiply step: add the shifted elapsed value for each set numerator bit
	assign acc_d = mplier_q[0] ? (acc_q + mcand_q) : acc_q;

	// Start the divider on the last multiply step
	assign div_req.start    = (state_q == ST_MUL) && (mcnt_q == MUL_CNT_W'(SCALE_W - 1));
	assign div_req.dividend = acc_d;
	assign div_req.divisor  = divisor;

	rts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= SCALE_W'(1);
			den_q <= SCALE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUMERATOR:   num_q <= cfg_data;
				CFG_DENOMINATOR: den_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Sequencer and scaler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mcnt_q  <= '0;
			prev_q  <= '0;
			rem_q   <= '0;
			count_q <= TIME_W'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take && !passthru) begin
						prev_q  <= raw.raw_time;
						mcnt_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (div_req.start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						count_q <= count_q + div_rsp.quotient;
						rem_q   <= div_rsp.remainder;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Multiplier datapath: load elapsed ticks and numerator, shift each cycle of the multiply state
	always_ff @(posedge clk) begin
		if (in_take) begin
			mcand_q  <= raw.raw_time - prev_q;
			mplier_q <= num_q;
			acc_q    <= {{(TIME_W - SCALE_W){1'b0}}, rem_q};
		end else if (state_q == ST_MUL) begin
			mcand_q  <= {mcand_q[TIME_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[SCALE_W-1:1]};
			acc_q    <= acc_d;
		end
	end

	// Output register: load pass-through samples or finished counts, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_take && passthru) || ((state_q == ST_FIN) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (scaled.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && passthru) begin
			out_data_q <= raw.raw_time;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_data_q <= count_q;
		end
	end

	assign scaled.valid       = out_valid_q;
	assign scaled.scaled_time = out_data_q;

	// Accept requests only when idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		raw.ready |-> (state_q == ST_IDLE))
		else $error("request accepted while busy");

	// Never restart the divider while it works
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// Divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("unexpected divider completion");

	// Remainder stays below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (div_rsp.remainder < divisor))
		else $error("remainder out of range");

	// Output data holds while a result waits
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !scaled.ready) |=> $stable(out_data_q))
		else $error("waiting result changed");

endmodule

// ----- tb/sv/rational_timebase_scaler_test.sv -----
// Self-checking testbench for the rational timebase scaler: samples in, scaled counts checked.
`timescale 1ns / 1ps

module rational_timebase_scaler_test;
	import rts_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned PHASE_ITEMS  = 55;
	localparam int unsigned RAND_PHASES  = 10;
	localparam int unsigned HOLD_AT      = 100;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned SETTLE       = 4;
	localparam int unsigned DRAIN_CYCLES = 100;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCALE_W-1:0]   cfg_data;

	rts_raw_if    raw_if();
	rts_scaled_if scaled_if();

	rational_timebase_scaler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw_if),
		.scaled    (scaled_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the scaler state and its two scale registers
	bit [SCALE_W-1:0] num_reg     = 1;
	bit [SCALE_W-1:0] den_reg     = 1;
	bit [TIME_W-1:0]  last_sample = '0;
	bit [SCALE_W-1:0] carry_rem   = '0;
	bit [TIME_W-1:0]  tick_count  = 1;

	bit [TIME_W-1:0] pending_samples[$];
	bit [TIME_W-1:0] expected_counts[$];

	int unsigned idle_odds = 5;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// Driver and monitor bookkeeping
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned results_seen = 0;
	bit [TIME_W-1:0] want;

	always #5 clk = ~clk;

	// Advance the shadow state by one sample and return the count it should produce
	function automatic bit [TIME_W-1:0] scale_sample(bit [TIME_W-1:0] sample);
		bit [TIME_W-1:0] elapsed;
		bit [TIME_W-1:0] divisor;
		bit [TIME_W-1:0] quotient;
		if (num_reg == den_reg)
			return sample;
		elapsed = (sample - last_sample) * {32'b0, num_reg} + {32'b0, carry_rem};
		last_sample = sample;
		divisor = (den_reg == 0) ? 64'd1 : {32'b0, den_reg};
		quotient = elapsed / divisor;
		carry_rem = SCALE_W'(elapsed - quotient * divisor);
		tick_count = tick_count + quotient;
		return tick_count;
	endfunction

	// Pick a scale value, biased toward the extremes and small ratios
	function automatic bit [SCALE_W-1:0] pick_scale();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return 1;
			2: return '1;
			3, 4: return $urandom_range(16, 1);
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [SCALE_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_NUMERATOR)
			num_reg = value;
		else
			den_reg = value;
	endtask

	// Wait until every request is sent and every result is back
	task automatic wait_idle();
		while (pending_samples.size() != 0 || expected_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_scale(bit [SCALE_W-1:0] num, bit [SCALE_W-1:0] den);
		wait_idle();
		write_reg(CFG_NUMERATOR, num);
		write_reg(CFG_DENOMINATOR, den);
	endtask

	// Sample driver: hold an offered request until taken, insert idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_if.valid    <= 1'b0;
			raw_if.raw_time <= '0;
			send_gap = 0;
		end else begin
			if (raw_if.valid && raw_if.ready) begin
				expected_counts.push_back(scale_sample(raw_if.raw_time));
				void'(pending_samples.pop_front());
			end
			if (raw_if.valid && !raw_if.ready) begin
				// hold the request and its payload
			end else if (send_gap != 0) begin
				raw_if.valid <= 1'b0;
				send_gap = send_gap - 1;
			end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
				raw_if.valid <= 1'b0;
				send_gap = $urandom_range(17, 0);
			end else if (pending_samples.size() != 0) begin
				raw_if.valid    <= 1'b1;
				raw_if.raw_time <= pending_samples[0];
			end else begin
				raw_if.valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare against the oldest expected count, drive ready stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scaled_if.ready <= 1'b0;
		end else begin
			if (scaled_if.valid && scaled_if.ready) begin
				results_seen = results_seen + 1;
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h",
						$time, scaled_if.scaled_time);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = expected_counts.pop_front();
					if (scaled_if.scaled_time !== want) begin
						$display("%0t: scaled_time mismatch: expected %h, actual %h",
							$time, want, scaled_if.scaled_time);
						mismatch_count = mismatch_count + 1;
					end
				end
			end
			if (hold_left != 0) begin
				scaled_if.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else if (!hold_done && results_seen == HOLD_AT) begin
				// back off long enough for the block to fill and stall its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				scaled_if.ready <= 1'b0;
			end else if (stall_left != 0) begin
				scaled_if.ready <= 1'b0;
				stall_left = stall_left - 1;
			end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
				scaled_if.ready <= 1'b0;
				stall_left = $urandom_range(17, 0);
			end else begin
				scaled_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus
	initial begin
		bit [TIME_W-1:0]  stim_time;
		bit [SCALE_W-1:0] num;
		bit [SCALE_W-1:0] den;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_NUMERATOR;
		cfg_data        = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Unit scale after reset: samples pass straight through
		pending_samples.push_back(64'h0);
		pending_samples.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		pending_samples.push_back(64'h5555_5555_5555_5555);
		pending_samples.push_back(64'hAAAA_AAAA_AAAA_AAAA);

		// Plain ratio, counter stepping back and wrapping through zero
		set_scale(3, 7);
		pending_samples.push_back(64'd10);
		pending_samples.push_back(64'd25);
		pending_samples.push_back(64'd1000);
		pending_samples.push_back(64'd5);
		pending_samples.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		pending_samples.push_back(64'd2);

		// Largest numerator: the product wraps
		set_scale('1, 1);
		pending_samples.push_back(64'd1);
		pending_samples.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		pending_samples.push_back(64'h0123_4567_89AB_CDEF);

		// Zero denominator divides by one
		set_scale(5, 0);
		pending_samples.push_back(64'd100);
		pending_samples.push_back(64'd7);
		pending_samples.push_back(64'd9000);

		// Both registers zero: passthrough
		set_scale(0, 0);
		pending_samples.push_back(64'd42);
		pending_samples.push_back(64'h8000_0000_0000_0000);

		// Largest denominator leaves big remainders
		set_scale(1, '1);
		pending_samples.push_back(64'h0000_0001_0000_0000);
		pending_samples.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		pending_samples.push_back(64'd12);

		// Zero numerator: only the carried remainder feeds the divide
		set_scale(0, 9);
		pending_samples.push_back(64'd1);
		pending_samples.push_back(64'd2);

		// Random phases: mostly a rising counter, some jumps, steps back and wraps
		stim_time = 64'd2;
		for (int p = 0; p < RAND_PHASES; p++) begin
			num = pick_scale();
			den = ($urandom_range(5, 0) == 0) ? num : pick_scale();
			set_scale(num, den);
			if (p == RAND_PHASES - 1 || $urandom_range(3, 0) == 0)
				idle_odds = 0;
			else
				idle_odds = $urandom_range(10, 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(19, 0))
					0: stim_time = {$urandom, $urandom};
					1: stim_time = stim_time - $urandom_range(1000, 1);
					2: stim_time = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(50, 0);
					default: stim_time = stim_time + ({$urandom, $urandom} >> $urandom_range(63, 16));
				endcase
				pending_samples.push_back(stim_time);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_counts.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, expected_counts.size());
		if (mismatch_count == 0 && expected_counts.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
